### design/avimjw_pkg.sv
// Shared types, command codes, FourCC words and resolution tables
// for the AVI Motion-JPEG container writer. No dependencies.
`default_nettype none

package avimjw_pkg;

	localparam int HEADER_RESERVE_DEF = 512;

	// step counter covers the 56 header words and the zero-fill runs
	localparam int STEP_W    = 6;
	localparam int HDR_WORDS = 56;

	localparam logic [1:0] CMD_START    = 2'd0;
	localparam logic [1:0] CMD_HEADER   = 2'd1;
	localparam logic [1:0] CMD_DATA     = 2'd2;
	localparam logic [1:0] CMD_FINALIZE = 2'd3;

	localparam logic [31:0] FCC_RIFF = 32'h4646_4952;
	localparam logic [31:0] FCC_AVI  = 32'h2049_5641;
	localparam logic [31:0] FCC_LIST = 32'h5453_494C;
	localparam logic [31:0] FCC_HDRL = 32'h6C72_6468;
	localparam logic [31:0] FCC_AVIH = 32'h6869_7661;
	localparam logic [31:0] FCC_STRL = 32'h6C72_7473;
	localparam logic [31:0] FCC_STRH = 32'h6872_7473;
	localparam logic [31:0] FCC_VIDS = 32'h7364_6976;
	localparam logic [31:0] FCC_MJPG = 32'h4750_4A4D;
	localparam logic [31:0] FCC_STRF = 32'h6672_7473;
	localparam logic [31:0] FCC_MOVI = 32'h6976_6F6D;
	localparam logic [31:0] FCC_00DC = 32'h6364_3030;

	localparam logic [31:0] US_PER_FRAME = 32'(1000000 / 30);
	localparam logic [31:0] HDRL_SIZE    = 32'd192;
	localparam logic [31:0] STRL_SIZE    = 32'd116;
	localparam logic [31:0] AVIH_SIZE    = 32'd56;
	localparam logic [31:0] STRF_SIZE    = 32'd40;
	localparam logic [31:0] FRAME_RATE   = 32'd30;
	localparam logic [31:0] PLANES_BPP   = 32'h0018_0001;
	// riff size = 4 + (8 + hdrl) + 8 + movi, movi = total + 4
	localparam logic [31:0] RIFF_EXTRA   = 32'd216;
	localparam logic [31:0] MOVI_EXTRA   = 32'd4;

	typedef struct packed {
		logic [1:0]  command;
		logic [23:0] frame_length;
		logic [31:0] data_word;
		logic [2:0]  data_bytes;
		logic        frame_end;
	} in_word_t;

	typedef struct packed {
		logic [31:0] write_offset;
		logic [31:0] write_data;
		logic [9:0]  byte_count;
		logic        zero_fill;
		logic        last_of_run;
	} out_word_t;

	// controller -> datapath
	typedef struct packed {
		logic              load;
		logic              advance;
		logic [STEP_W-1:0] step;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;
		logic step_emits;
		logic step_last;
	} dp_status_t;

	function automatic logic [10:0] res_width(input logic [2:0] sel);
		logic [10:0] w;
		unique case (sel)
			3'd0:    w = 11'd160;
			3'd1:    w = 11'd320;
			3'd2:    w = 11'd400;
			3'd4:    w = 11'd800;
			3'd5:    w = 11'd1024;
			default: w = 11'd640;
		endcase
		return w;
	endfunction

	function automatic logic [9:0] res_height(input logic [2:0] sel);
		logic [9:0] h;
		unique case (sel)
			3'd0:    h = 10'd120;
			3'd1:    h = 10'd240;
			3'd2:    h = 10'd296;
			3'd4:    h = 10'd600;
			3'd5:    h = 10'd768;
			default: h = 10'd480;
		endcase
		return h;
	endfunction

	// width * height * 3
	function automatic logic [31:0] res_image_bytes(input logic [2:0] sel);
		logic [31:0] b;
		unique case (sel)
			3'd0:    b = 32'd57600;
			3'd1:    b = 32'd230400;
			3'd2:    b = 32'd355200;
			3'd4:    b = 32'd1440000;
			3'd5:    b = 32'd2359296;
			default: b = 32'd921600;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

### design/avimjw_ctrl.sv
// Step sequencer for the container writer: takes input words and walks
// the result steps of each. Depends on avimjw_pkg.
`default_nettype none

module avimjw_ctrl (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_stall,
	input  avimjw_pkg::dp_status_t   status,
	output avimjw_pkg::dp_cmd_t      cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic                          state_q;
	logic [avimjw_pkg::STEP_W-1:0] step_q;
	logic                          go;
	logic                          done;
	logic                          accept;

	assign go     = (state_q == ST_RUN) && (!status.step_emits || status.out_free);
	assign done   = go && status.step_last;
	assign in_stall = !((state_q == ST_IDLE) || done);
	assign accept = in_valid && !in_stall;

	assign cmd.load    = accept;
	assign cmd.advance = go;
	assign cmd.step    = step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			priority if (accept) begin
				state_q <= ST_RUN;
				step_q  <= '0;
			end else if (done) begin
				state_q <= ST_IDLE;
				step_q  <= '0;
			end else if (go) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (step_q < avimjw_pkg::STEP_W'(avimjw_pkg::HDR_WORDS)))
		else $error("step counter beyond header length");

	a_load_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RUN) && (step_q == '0))
		else $error("accepted word did not start at step 0");

	a_step_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(go && !status.step_last) |=> (step_q == $past(step_q) + 1'b1))
		else $error("step did not advance");

endmodule

`default_nettype wire

### design/avimjw_dp.sv
// Datapath: item register, file counters, resolution register, header
// word mux and the output register. Depends on avimjw_pkg.
`default_nettype none

module avimjw_dp #(
	parameter int HEADER_RESERVE = avimjw_pkg::HEADER_RESERVE_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      resolution_select_wr_en,
	input  wire  [2:0]               resolution_select,
	input  avimjw_pkg::in_word_t     in_word,
	output logic                     out_valid,
	input  wire                      out_stall,
	output avimjw_pkg::out_word_t    out_word,
	input  avimjw_pkg::dp_cmd_t      cmd,
	output avimjw_pkg::dp_status_t   status
);

	localparam int NRUNS    = (HEADER_RESERVE + 511) / 512;
	localparam int LAST_RUN = HEADER_RESERVE - 512 * (NRUNS - 1);
	localparam int SW       = avimjw_pkg::STEP_W;

	avimjw_pkg::in_word_t  item_q;
	avimjw_pkg::out_word_t out_q;
	logic                  out_valid_q;
	logic [2:0]            res_sel_q;
	logic [2:0]            lat_res_q;
	logic                  active_q;
	logic                  odd_q;
	logic [31:0]           next_off_q;
	logic [31:0]           total_q;
	logic [31:0]           frames_q;

	logic [2:0]            nb;
	logic [31:0]           data_masked;
	logic                  has_data;
	logic                  has_pad;
	logic                  emits;
	logic                  last;
	logic                  out_free;
	logic [31:0]           hdr_word;
	logic [31:0]           riff_size;
	logic [31:0]           movi_size;
	logic [10:0]           img_w;
	logic [9:0]            img_h;
	avimjw_pkg::out_word_t res_w;

	assign out_free = !out_valid_q || !out_stall;
	assign nb       = (item_q.data_bytes > 3'd4) ? 3'd4 : item_q.data_bytes;
	assign has_data = (nb != 3'd0);
	assign has_pad  = item_q.frame_end && odd_q;

	always_comb begin
		unique case (nb)
			3'd1:    data_masked = {24'd0, item_q.data_word[7:0]};
			3'd2:    data_masked = {16'd0, item_q.data_word[15:0]};
			3'd3:    data_masked = {8'd0, item_q.data_word[23:0]};
			3'd4:    data_masked = item_q.data_word;
			default: data_masked = 32'd0;
		endcase
	end

	// which steps produce a word, and which step ends the item
	always_comb begin
		emits = 1'b0;
		last  = 1'b1;
		unique case (item_q.command)
			avimjw_pkg::CMD_START: begin
				emits = 1'b1;
				last  = (cmd.step == SW'(NRUNS - 1));
			end
			avimjw_pkg::CMD_HEADER: begin
				emits = active_q;
				last  = !active_q || (cmd.step == SW'(1));
			end
			avimjw_pkg::CMD_DATA: begin
				if (!active_q) begin
					emits = 1'b0;
					last  = 1'b1;
				end else if (cmd.step == '0) begin
					emits = has_data;
					last  = !has_pad;
				end else begin
					emits = has_pad;
					last  = 1'b1;
				end
			end
			avimjw_pkg::CMD_FINALIZE: begin
				emits = active_q;
				last  = !active_q ||
					(cmd.step == SW'(avimjw_pkg::HDR_WORDS - 1));
			end
		endcase
	end

	assign status.out_free   = out_free;
	assign status.step_emits = emits;
	assign status.step_last  = last;

	assign img_w     = avimjw_pkg::res_width(lat_res_q);
	assign img_h     = avimjw_pkg::res_height(lat_res_q);
	assign riff_size = total_q + avimjw_pkg::RIFF_EXTRA;
	assign movi_size = total_q + avimjw_pkg::MOVI_EXTRA;

	always_comb begin
		unique case (cmd.step)
			SW'(0):  hdr_word = avimjw_pkg::FCC_RIFF;
			SW'(1):  hdr_word = riff_size;
			SW'(2):  hdr_word = avimjw_pkg::FCC_AVI;
			SW'(3):  hdr_word = avimjw_pkg::FCC_LIST;
			SW'(4):  hdr_word = avimjw_pkg::HDRL_SIZE;
			SW'(5):  hdr_word = avimjw_pkg::FCC_HDRL;
			SW'(6):  hdr_word = avimjw_pkg::FCC_AVIH;
			SW'(7):  hdr_word = avimjw_pkg::AVIH_SIZE;
			SW'(8):  hdr_word = avimjw_pkg::US_PER_FRAME;
			SW'(12): hdr_word = frames_q;
			SW'(14): hdr_word = 32'd1;
			SW'(16): hdr_word = {21'd0, img_w};
			SW'(17): hdr_word = {22'd0, img_h};
			SW'(22): hdr_word = avimjw_pkg::FCC_LIST;
			SW'(23): hdr_word = avimjw_pkg::STRL_SIZE;
			SW'(24): hdr_word = avimjw_pkg::FCC_STRL;
			SW'(25): hdr_word = avimjw_pkg::FCC_STRH;
			SW'(26): hdr_word = avimjw_pkg::AVIH_SIZE;
			SW'(27): hdr_word = avimjw_pkg::FCC_VIDS;
			SW'(28): hdr_word = avimjw_pkg::FCC_MJPG;
			SW'(32): hdr_word = 32'd1;
			SW'(33): hdr_word = avimjw_pkg::FRAME_RATE;
			SW'(35): hdr_word = frames_q;
			SW'(40): hdr_word = {6'd0, img_h, 5'd0, img_w};
			SW'(41): hdr_word = avimjw_pkg::FCC_STRF;
			SW'(42): hdr_word = avimjw_pkg::STRF_SIZE;
			SW'(43): hdr_word = avimjw_pkg::STRF_SIZE;
			SW'(44): hdr_word = {21'd0, img_w};
			SW'(45): hdr_word = {22'd0, img_h};
			SW'(46): hdr_word = avimjw_pkg::PLANES_BPP;
			SW'(47): hdr_word = avimjw_pkg::FCC_MJPG;
			SW'(48): hdr_word = avimjw_pkg::res_image_bytes(lat_res_q);
			SW'(53): hdr_word = avimjw_pkg::FCC_LIST;
			SW'(54): hdr_word = movi_size;
			SW'(55): hdr_word = avimjw_pkg::FCC_MOVI;
			default: hdr_word = 32'd0;
		endcase
	end

	// result word for the current step
	always_comb begin
		res_w.write_offset = next_off_q;
		res_w.write_data   = 32'd0;
		res_w.byte_count   = 10'd4;
		res_w.zero_fill    = 1'b0;
		res_w.last_of_run  = last;
		unique case (item_q.command)
			avimjw_pkg::CMD_START: begin
				res_w.write_offset = {{(32 - SW - 9){1'b0}}, cmd.step, 9'd0};
				res_w.byte_count   = last ? 10'(LAST_RUN) : 10'd512;
				res_w.zero_fill    = 1'b1;
			end
			avimjw_pkg::CMD_HEADER: begin
				res_w.write_data = (cmd.step == '0) ? avimjw_pkg::FCC_00DC
					: {8'd0, item_q.frame_length};
			end
			avimjw_pkg::CMD_DATA: begin
				if (cmd.step == '0) begin
					res_w.write_data = data_masked;
					res_w.byte_count = {7'd0, nb};
				end else begin
					res_w.byte_count = 10'd1;
					res_w.zero_fill  = 1'b1;
				end
			end
			avimjw_pkg::CMD_FINALIZE: begin
				res_w.write_offset = {{(32 - SW - 2){1'b0}}, cmd.step, 2'd0};
				res_w.write_data   = hdr_word;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			item_q <= in_word;
		if (cmd.advance && emits)
			out_q <= res_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			res_sel_q   <= 3'd3;
			lat_res_q   <= 3'd3;
			active_q    <= 1'b0;
			odd_q       <= 1'b0;
			next_off_q  <= '0;
			total_q     <= '0;
			frames_q    <= '0;
		end else begin
			if (resolution_select_wr_en)
				res_sel_q <= resolution_select;

			if (cmd.advance && emits)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			if (cmd.advance) begin
				unique case (item_q.command)
					avimjw_pkg::CMD_START: begin
						active_q   <= 1'b1;
						next_off_q <= 32'(HEADER_RESERVE);
						total_q    <= '0;
						frames_q   <= '0;
						odd_q      <= 1'b0;
						lat_res_q  <= res_sel_q;
					end
					avimjw_pkg::CMD_HEADER: begin
						if (active_q) begin
							next_off_q <= next_off_q + 32'd4;
							if (cmd.step != '0) begin
								odd_q    <= item_q.frame_length[0];
								total_q  <= total_q + {8'd0, item_q.frame_length}
									+ 32'd8 + {31'd0, item_q.frame_length[0]};
								frames_q <= frames_q + 32'd1;
							end
						end
					end
					avimjw_pkg::CMD_DATA: begin
						if (active_q) begin
							if (cmd.step == '0)
								next_off_q <= next_off_q + {29'd0, nb};
							else
								next_off_q <= next_off_q + 32'd1;
							if (last && item_q.frame_end)
								odd_q <= 1'b0;
						end
					end
					avimjw_pkg::CMD_FINALIZE: begin
						if (active_q && last)
							active_q <= 1'b0;
					end
				endcase
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.advance && emits) |-> out_free)
		else $error("output register overwritten while held");

	a_start_arms: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.advance && item_q.command == avimjw_pkg::CMD_START) |=> active_q)
		else $error("start did not open the file");

	a_pad_needs_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.advance && emits && item_q.command == avimjw_pkg::CMD_DATA
			&& cmd.step != '0) |-> odd_q)
		else $error("pad byte on an even frame");

endmodule

`default_nettype wire

### design/avi_mjpeg_container_writer_top.sv
// Top level of the AVI Motion-JPEG container writer: sequencer plus
// datapath. Depends on avimjw_pkg, avimjw_ctrl and avimjw_dp.
`default_nettype none

//  channel   direction  handshake            word
//  in        sink       in_valid / in_stall   avimjw_pkg::in_word_t
//  out       source     out_valid / out_stall avimjw_pkg::out_word_t
//  config    sink       resolution_select_wr_en resolution_select[2:0]
//
//  Cycles: at most one result word per clock while out is not stalled. A data
//  word gives its data bytes (plus a pad byte at the end of an odd frame), a frame
//  header two words, start ceil(HEADER_RESERVE/512) zero-fill runs, finalize 56
//  header words. A new word is taken in the cycle of the current one's last step.
//  Reset: arst_n asynchronous, active low; no memory, no clearing pass.
//  Stalls: out_stall holds the output register and reaches in_stall directly.

module avi_mjpeg_container_writer_top #(
	parameter int HEADER_RESERVE = avimjw_pkg::HEADER_RESERVE_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      resolution_select_wr_en,
	input  wire  [2:0]               resolution_select,
	input  wire                      in_valid,
	output logic                     in_stall,
	input  avimjw_pkg::in_word_t     in_word,
	output logic                     out_valid,
	input  wire                      out_stall,
	output avimjw_pkg::out_word_t    out_word
);

	// step commands go down, emit/last/free status comes back
	avimjw_pkg::dp_cmd_t    dp_cmd;
	avimjw_pkg::dp_status_t dp_status;

	avimjw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (dp_status),
		.cmd      (dp_cmd)
	);

	avimjw_dp #(
		.HEADER_RESERVE (HEADER_RESERVE)
	) u_dp (
		.clk                     (clk),
		.arst_n                  (arst_n),
		.resolution_select_wr_en (resolution_select_wr_en),
		.resolution_select       (resolution_select),
		.in_word                 (in_word),
		.out_valid               (out_valid),
		.out_stall               (out_stall),
		.out_word                (out_word),
		.cmd                     (dp_cmd),
		.status                  (dp_status)
	);

endmodule

`default_nettype wire
